/* rtl/aclsq_pkg.sv */
// ----------------------------------------------------------------------------
// aclsq_pkg
// types, codes and the solve program of the affine calibration block
// ----------------------------------------------------------------------------
package aclsq_pkg;

  // input word: one calibration point
  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic        [14:0] screen_x;
    logic        [14:0] screen_y;
    logic               last_point;
  } in_word_t;

  // output word: status and six q16.16 coefficients
  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] coef_e;
    logic signed [31:0] coef_f;
  } out_word_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_FEW   = 2'd1;
  localparam logic [1:0] STATUS_SINGULAR  = 2'd2;
  localparam logic [1:0] STATUS_SATURATED = 2'd3;

  localparam int unsigned SUM_W     = 40;
  localparam int unsigned NUM_SUMS  = 11;
  localparam int unsigned NUM_REGS  = 12;
  localparam int unsigned CALC_W    = 144;
  localparam int unsigned CNT_W     = $clog2(CALC_W);
  localparam int unsigned PC_W      = 6;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned MIN_POINTS = 3;
  localparam int unsigned Q_SHIFT   = 17;

  // scratch registers
  localparam logic [4:0] R_CXX  = 5'd0;
  localparam logic [4:0] R_CXY  = 5'd1;
  localparam logic [4:0] R_CYY  = 5'd2;
  localparam logic [4:0] R_DET  = 5'd3;
  localparam logic [4:0] R_NA   = 5'd4;
  localparam logic [4:0] R_NB   = 5'd5;
  localparam logic [4:0] R_NC   = 5'd6;
  localparam logic [4:0] R_DETN = 5'd7;
  localparam logic [4:0] R_T0   = 5'd8;
  localparam logic [4:0] R_T1   = 5'd9;
  localparam logic [4:0] R_UX   = 5'd10;
  localparam logic [4:0] R_UY   = 5'd11;

  // moment sums and point count as sources
  localparam logic [4:0] SRC_SXX  = 5'd16;
  localparam logic [4:0] SRC_SXY  = 5'd17;
  localparam logic [4:0] SRC_SX   = 5'd18;
  localparam logic [4:0] SRC_SYY  = 5'd19;
  localparam logic [4:0] SRC_SY   = 5'd20;
  localparam logic [4:0] SRC_SXSX = 5'd21;
  localparam logic [4:0] SRC_SYSX = 5'd22;
  localparam logic [4:0] SRC_SSX  = 5'd23;
  localparam logic [4:0] SRC_SXSY = 5'd24;
  localparam logic [4:0] SRC_SYSY = 5'd25;
  localparam logic [4:0] SRC_SSY  = 5'd26;
  localparam logic [4:0] SRC_N    = 5'd27;

  // coefficient slots
  localparam logic [4:0] COEF_A = 5'd0;
  localparam logic [4:0] COEF_B = 5'd1;
  localparam logic [4:0] COEF_C = 5'd2;
  localparam logic [4:0] COEF_D = 5'd3;
  localparam logic [4:0] COEF_E = 5'd4;
  localparam logic [4:0] COEF_F = 5'd5;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_SUB,
    OP_SUBZ,
    OP_Q16,
    OP_END
  } uop_op_e;

  typedef struct packed {
    uop_op_e    op;
    logic [4:0] dst;
    logic [4:0] src_a;
    logic [4:0] src_b;
  } uop_t;

  // solve program: centered moments, 2x2 determinant, then both axes
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = '{OP_MUL,  R_T0,   SRC_N,    SRC_SXX};
      6'd1:  u = '{OP_MUL,  R_T1,   SRC_SX,   SRC_SX};
      6'd2:  u = '{OP_SUB,  R_CXX,  R_T0,     R_T1};
      6'd3:  u = '{OP_MUL,  R_T0,   SRC_N,    SRC_SXY};
      6'd4:  u = '{OP_MUL,  R_T1,   SRC_SX,   SRC_SY};
      6'd5:  u = '{OP_SUB,  R_CXY,  R_T0,     R_T1};
      6'd6:  u = '{OP_MUL,  R_T0,   SRC_N,    SRC_SYY};
      6'd7:  u = '{OP_MUL,  R_T1,   SRC_SY,   SRC_SY};
      6'd8:  u = '{OP_SUB,  R_CYY,  R_T0,     R_T1};
      6'd9:  u = '{OP_MUL,  R_T0,   R_CXX,    R_CYY};
      6'd10: u = '{OP_MUL,  R_T1,   R_CXY,    R_CXY};
      6'd11: u = '{OP_SUBZ, R_DET,  R_T0,     R_T1};
      6'd12: u = '{OP_MUL,  R_DETN, R_DET,    SRC_N};
      // screen x
      6'd13: u = '{OP_MUL,  R_T0,   SRC_N,    SRC_SXSX};
      6'd14: u = '{OP_MUL,  R_T1,   SRC_SX,   SRC_SSX};
      6'd15: u = '{OP_SUB,  R_UX,   R_T0,     R_T1};
      6'd16: u = '{OP_MUL,  R_T0,   SRC_N,    SRC_SYSX};
      6'd17: u = '{OP_MUL,  R_T1,   SRC_SY,   SRC_SSX};
      6'd18: u = '{OP_SUB,  R_UY,   R_T0,     R_T1};
      6'd19: u = '{OP_MUL,  R_T0,   R_CYY,    R_UX};
      6'd20: u = '{OP_MUL,  R_T1,   R_CXY,    R_UY};
      6'd21: u = '{OP_SUB,  R_NA,   R_T0,     R_T1};
      6'd22: u = '{OP_MUL,  R_T0,   R_CXX,    R_UY};
      6'd23: u = '{OP_MUL,  R_T1,   R_CXY,    R_UX};
      6'd24: u = '{OP_SUB,  R_NB,   R_T0,     R_T1};
      6'd25: u = '{OP_MUL,  R_T0,   SRC_SSX,  R_DET};
      6'd26: u = '{OP_MUL,  R_T1,   R_NA,     SRC_SX};
      6'd27: u = '{OP_SUB,  R_T0,   R_T0,     R_T1};
      6'd28: u = '{OP_MUL,  R_T1,   R_NB,     SRC_SY};
      6'd29: u = '{OP_SUB,  R_NC,   R_T0,     R_T1};
      6'd30: u = '{OP_Q16,  COEF_A, R_NA,     R_DET};
      6'd31: u = '{OP_Q16,  COEF_B, R_NB,     R_DET};
      6'd32: u = '{OP_Q16,  COEF_C, R_NC,     R_DETN};
      // screen y
      6'd33: u = '{OP_MUL,  R_T0,   SRC_N,    SRC_SXSY};
      6'd34: u = '{OP_MUL,  R_T1,   SRC_SX,   SRC_SSY};
      6'd35: u = '{OP_SUB,  R_UX,   R_T0,     R_T1};
      6'd36: u = '{OP_MUL,  R_T0,   SRC_N,    SRC_SYSY};
      6'd37: u = '{OP_MUL,  R_T1,   SRC_SY,   SRC_SSY};
      6'd38: u = '{OP_SUB,  R_UY,   R_T0,     R_T1};
      6'd39: u = '{OP_MUL,  R_T0,   R_CYY,    R_UX};
      6'd40: u = '{OP_MUL,  R_T1,   R_CXY,    R_UY};
      6'd41: u = '{OP_SUB,  R_NA,   R_T0,     R_T1};
      6'd42: u = '{OP_MUL,  R_T0,   R_CXX,    R_UY};
      6'd43: u = '{OP_MUL,  R_T1,   R_CXY,    R_UX};
      6'd44: u = '{OP_SUB,  R_NB,   R_T0,     R_T1};
      6'd45: u = '{OP_MUL,  R_T0,   SRC_SSY,  R_DET};
      6'd46: u = '{OP_MUL,  R_T1,   R_NA,     SRC_SX};
      6'd47: u = '{OP_SUB,  R_T0,   R_T0,     R_T1};
      6'd48: u = '{OP_MUL,  R_T1,   R_NB,     SRC_SY};
      6'd49: u = '{OP_SUB,  R_NC,   R_T0,     R_T1};
      6'd50: u = '{OP_Q16,  COEF_D, R_NA,     R_DET};
      6'd51: u = '{OP_Q16,  COEF_E, R_NB,     R_DET};
      6'd52: u = '{OP_Q16,  COEF_F, R_NC,     R_DETN};
      default: u = '{OP_END, R_CXX, R_CXX,    R_CXX};
    endcase
    return u;
  endfunction

endpackage

/* rtl/affine_calibration_least_squares.sv */
// ----------------------------------------------------------------------------
// affine_calibration_least_squares
// exact least-squares affine touch calibration, q16.16 coefficients
// ----------------------------------------------------------------------------
// usage
//   in channel: one word per calibration point (raw x/y, screen x/y, last
//   flag), taken when in_valid_i is high and in_stall_o is low
//   out channel: one word per point marked last (status plus six
//   coefficients), held in an output register until out_stall_i is low
//   a point updates the eleven moment sums in turn through one 17x17
//   multiplier and a 40-bit adder; in_stall_o is high meanwhile
//   a last point starts the solve: a program of 53 steps on one 144-bit
//   add/subtract unit, each multiply and divide a bit a cycle; with
//   fewer than 3 points the result follows without the solve, and a zero
//   determinant ends the solve early
//   a stalled result waits in the output register; the next point is
//   taken meanwhile, only a new result waits for the register to free
//   reset clears the sums, the point count and the output valid
//   after each result the sums and the count clear
// ----------------------------------------------------------------------------
module affine_calibration_least_squares
  import aclsq_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_CHK,
    ST_LDA,
    ST_LDB,
    ST_MUL,
    ST_SUB,
    ST_NEG,
    ST_PREP,
    ST_DIV,
    ST_SAT,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic [PC_W-1:0]           pc_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [3:0]                k_q;
  logic [COUNT_W-1:0]        count_q;
  logic signed [SUM_W-1:0]   sums_q [NUM_SUMS];
  logic [1:0]                status_q;
  logic                      sat_q;
  logic                      neg_q;
  logic                      out_valid_q;
  out_word_t                 out_q;

  // datapath registers
  in_word_t                  in_q;
  logic [CALC_W-1:0]         a_q;
  logic [CALC_W-1:0]         b_q;
  logic [CALC_W-1:0]         acc_q;
  logic [CALC_W-1:0]         rf_q [NUM_REGS];
  logic [31:0]               coef_q [6];

  uop_t                      uop;
  logic                      in_acc;
  logic                      out_free;
  logic                      cnt_last;

  assign uop      = uop_rom(pc_q);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_last = (cnt_q == CNT_W'(CALC_W - 1));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // moment update: one product a cycle
  logic signed [16:0] mop1, mop2;
  logic signed [33:0] mprod;
  logic signed [SUM_W-1:0] msum;

  always_comb begin
    case (k_q) inside
      4'd0, 4'd1, 4'd2, 4'd5, 4'd8: mop1 = {in_q.raw_x[15], in_q.raw_x};
      4'd3, 4'd4, 4'd6, 4'd9:       mop1 = {in_q.raw_y[15], in_q.raw_y};
      4'd7:                         mop1 = {2'b00, in_q.screen_x};
      default:                      mop1 = {2'b00, in_q.screen_y};
    endcase
    case (k_q) inside
      4'd0:       mop2 = {in_q.raw_x[15], in_q.raw_x};
      4'd1, 4'd3: mop2 = {in_q.raw_y[15], in_q.raw_y};
      4'd5, 4'd6: mop2 = {2'b00, in_q.screen_x};
      4'd8, 4'd9: mop2 = {2'b00, in_q.screen_y};
      default:    mop2 = 17'sd1;
    endcase
  end

  assign mprod = mop1 * mop2;
  assign msum  = sums_q[k_q] + {{(SUM_W - 34){mprod[33]}}, mprod};

  // operand read port: scratch registers, sums or point count
  logic [4:0]        rd_sel;
  logic [CALC_W-1:0] rd_data;

  assign rd_sel = (state_q == ST_LDA) ? uop.src_a : uop.src_b;

  always_comb begin
    rd_data = '0;
    if (rd_sel == SRC_N) begin
      rd_data = CALC_W'(count_q);
    end else if (rd_sel[4]) begin
      if (rd_sel[3:0] < 4'(NUM_SUMS)) begin
        rd_data = {{(CALC_W - SUM_W){sums_q[rd_sel[3:0]][SUM_W-1]}},
                   sums_q[rd_sel[3:0]]};
      end
    end else if (rd_sel[3:0] < 4'(NUM_REGS)) begin
      rd_data = rf_q[rd_sel[3:0]];
    end
  end

  // shared add/subtract unit
  logic [CALC_W-1:0] add_x, add_y;
  logic              add_sub;
  logic [CALC_W:0]   add_res;
  logic [CALC_W-1:0] rem_sh;

  assign rem_sh = {acc_q[CALC_W-2:0], a_q[CALC_W-1]};

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      ST_MUL: begin
        add_x = acc_q;
        add_y = a_q;
      end
      ST_SUB: begin
        add_x   = a_q;
        add_y   = b_q;
        add_sub = 1'b1;
      end
      ST_NEG: begin
        add_y   = a_q;
        add_sub = 1'b1;
      end
      ST_PREP: begin
        add_x = a_q << Q_SHIFT;
        add_y = b_q;
      end
      ST_DIV: begin
        add_x   = rem_sh;
        add_y   = b_q;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_res = {1'b0, add_x} + {1'b0, add_y ^ {CALC_W{add_sub}}}
                 + (CALC_W + 1)'(add_sub);

  logic [CALC_W-1:0] mul_next;
  logic              sub_zero;
  assign mul_next = b_q[0] ? add_res[CALC_W-1:0] : acc_q;
  assign sub_zero = (add_res[CALC_W-1:0] == '0);

  // rounding result: clamp to int32 and restore sign
  logic [31:0] q_limit, q_val, q_out;
  logic        q_over;
  assign q_limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign q_over  = (|a_q[CALC_W-1:32]) || (a_q[31:0] > q_limit);
  assign q_val   = q_over ? q_limit : a_q[31:0];
  assign q_out   = neg_q ? (32'd0 - q_val) : q_val;

  // sequencer, sums, count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      count_q     <= '0;
      status_q    <= STATUS_OK;
      sat_q       <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SUMS; i++) sums_q[i] <= '0;
    end else begin
      // the done step loads a new word itself
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            k_q <= '0;
            if (count_q < COUNT_W'(MAX_POINTS)) begin
              state_q <= ST_ACC;
            end else if (in_i.last_point) begin
              state_q <= ST_CHK;
            end
          end
        end
        ST_ACC: begin
          sums_q[k_q] <= msum;
          k_q         <= k_q + 4'd1;
          if (k_q == 4'(NUM_SUMS - 1)) begin
            count_q <= count_q + COUNT_W'(1);
            state_q <= in_q.last_point ? ST_CHK : ST_IDLE;
          end
        end
        ST_CHK: begin
          pc_q  <= '0;
          sat_q <= 1'b0;
          if (count_q < COUNT_W'(MIN_POINTS)) begin
            status_q <= STATUS_TOO_FEW;
            state_q  <= ST_DONE;
          end else begin
            state_q <= ST_LDA;
          end
        end
        ST_LDA: begin
          if (uop.op == OP_END) begin
            status_q <= sat_q ? STATUS_SATURATED : STATUS_OK;
            state_q  <= ST_DONE;
          end else begin
            state_q <= ST_LDB;
          end
        end
        ST_LDB: begin
          cnt_q <= '0;
          case (uop.op)
            OP_MUL:          state_q <= ST_MUL;
            OP_SUB, OP_SUBZ: state_q <= ST_SUB;
            default:         state_q <= ST_NEG;
          endcase
        end
        ST_MUL: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_last) begin
            pc_q    <= pc_q + PC_W'(1);
            state_q <= ST_LDA;
          end
        end
        ST_SUB: begin
          if (uop.op == OP_SUBZ && sub_zero) begin
            status_q <= STATUS_SINGULAR;
            state_q  <= ST_DONE;
          end else begin
            pc_q    <= pc_q + PC_W'(1);
            state_q <= ST_LDA;
          end
        end
        ST_NEG: begin
          neg_q   <= a_q[CALC_W-1];
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_last) state_q <= ST_SAT;
        end
        ST_SAT: begin
          sat_q   <= sat_q | q_over;
          pc_q    <= pc_q + PC_W'(1);
          state_q <= ST_LDA;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_q.status  <= status_q;
            out_q.coef_a  <= coef_q[0];
            out_q.coef_b  <= coef_q[1];
            out_q.coef_c  <= coef_q[2];
            out_q.coef_d  <= coef_q[3];
            out_q.coef_e  <= coef_q[4];
            out_q.coef_f  <= coef_q[5];
            count_q       <= '0;
            for (int i = 0; i < NUM_SUMS; i++) sums_q[i] <= '0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath: operands, accumulator, scratch registers, coefficients
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) in_q <= in_i;
      end
      ST_CHK: begin
        for (int i = 0; i < 6; i++) coef_q[i] <= '0;
      end
      ST_LDA: a_q <= rd_data;
      ST_LDB: begin
        b_q   <= rd_data;
        acc_q <= '0;
      end
      ST_MUL: begin
        acc_q <= mul_next;
        a_q   <= a_q << 1;
        b_q   <= b_q >> 1;
        if (cnt_last) rf_q[uop.dst[3:0]] <= mul_next;
      end
      ST_SUB: rf_q[uop.dst[3:0]] <= add_res[CALC_W-1:0];
      ST_NEG: begin
        if (a_q[CALC_W-1]) a_q <= add_res[CALC_W-1:0];
      end
      ST_PREP: begin
        a_q   <= add_res[CALC_W-1:0];
        b_q   <= b_q << 1;
        acc_q <= '0;
      end
      ST_DIV: begin
        acc_q <= add_res[CALC_W] ? add_res[CALC_W-1:0] : rem_sh;
        a_q   <= {a_q[CALC_W-2:0], add_res[CALC_W]};
      end
      ST_SAT: coef_q[uop.dst[2:0]] <= q_out;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside the done step");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (count_q == '0 && state_q == ST_IDLE))
    else $error("point count not cleared after a result");

  a_zero_coefs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.status == STATUS_TOO_FEW
                     || out_o.status == STATUS_SINGULAR))
    |-> (out_o.coef_a == 0 && out_o.coef_b == 0 && out_o.coef_c == 0
         && out_o.coef_d == 0 && out_o.coef_e == 0 && out_o.coef_f == 0))
    else $error("failed solve carries nonzero coefficients");
`endif

endmodule
